// File: rtl/core/gwj_pkg.sv
`default_nettype none
package gwj_pkg;

  localparam int MAX_GLYPHS_DEF = 256;

  localparam int TGT_W = 15;
  localparam int LEN_W = 9;
  localparam int IDX_W = 8;
  localparam int X_W   = 16;

  // The widest dividend is the compression dividend, whose product fits in 24 bits.
  localparam int NUM_W = TGT_W + LEN_W;
  localparam int DIV_W = LEN_W;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 32;

  localparam int FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_SHRINK,
    MODE_WIDEN
  } gwj_mode_t;

  typedef struct packed {
    gwj_mode_t          mode;
    logic               shrunk;
    logic               few_gaps;
    logic               slot_one;
    logic [IDX_W-1:0]   idx;
    logic [X_W-1:0]     x;
    logic [TGT_W-1:0]   target;
  } gwj_side_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DIV_W-1:0] div;
    gwj_side_t        side;
  } gwj_job_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] div;
    gwj_side_t        side;
  } gwj_dstage_t;

  typedef struct packed {
    gwj_mode_t        mode;
    logic             shrunk;
    logic [X_W-1:0]   x;
    logic [TGT_W-1:0] front;
    logic [X_W-1:0]   prod;
    logic [TGT_W-1:0] target;
  } gwj_fin_t;

endpackage
`default_nettype wire

// File: rtl/core/gwj_front.sv
`default_nettype none
module gwj_front import gwj_pkg::*; #(
  parameter int MAX_GLYPHS = MAX_GLYPHS_DEF
) (
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic                  fifo_full,
  output logic                       push,
  output gwj_job_t                   job
);

  logic [TGT_W-1:0] target;
  logic [TGT_W-1:0] adv;
  logic [LEN_W-1:0] len_raw;
  logic [LEN_W-1:0] len;
  logic [IDX_W-1:0] idx;
  logic [X_W-1:0]   x;
  logic [TGT_W-1:0] a_s;
  logic [TGT_W-1:0] a_w;
  logic [LEN_W-1:0] slot;
  logic [LEN_W-1:0] idx1;
  logic [NUM_W-1:0] prod;
  logic             in_word;
  logic             shrink;
  logic             widen;
  logic             few_gaps;

  assign target  = in_tdata[14:0];
  assign adv     = in_tdata[29:15];
  assign len_raw = in_tdata[38:30];
  assign idx     = in_tdata[46:39];
  assign x       = in_tdata[62:47];

  assign in_tready = !fifo_full;
  assign push      = in_tvalid && !fifo_full;

  always_comb begin
    len      = (int'(len_raw) > MAX_GLYPHS) ? LEN_W'(MAX_GLYPHS) : len_raw;
    in_word  = (len != '0) && ({1'b0, idx} < len);
    shrink   = target < adv;
    widen    = target > adv;
    a_s      = adv - target;
    a_w      = target - adv;
    slot     = len - LEN_W'(1);
    few_gaps = (slot[LEN_W-1:1] == '0);
    idx1     = {1'b0, idx} + LEN_W'(1);
    prod     = {{LEN_W{1'b0}}, a_s} * {{TGT_W{1'b0}}, idx1};

    job.side.shrunk   = shrink;
    job.side.few_gaps = few_gaps;
    job.side.slot_one = slot[0];
    job.side.idx      = idx;
    job.side.x        = x;
    job.side.target   = target;

    if (in_word && shrink) begin
      job.side.mode = MODE_SHRINK;
      job.num       = prod + NUM_W'(len[LEN_W-1:1]);
      job.div       = len;
    end else if (in_word && widen) begin
      job.side.mode = MODE_WIDEN;
      job.num       = NUM_W'(a_w);
      job.div       = few_gaps ? DIV_W'(1) : slot;
    end else begin
      job.side.mode = MODE_PASS;
      job.num       = '0;
      job.div       = DIV_W'(1);
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/gwj_fifo.sv
`default_nettype none
module gwj_fifo import gwj_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire gwj_job_t wr_job,
  output logic          full,
  input  wire logic     pop,
  output logic          rd_valid,
  output gwj_job_t      rd_job
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  gwj_job_t         mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign full     = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FIFO_DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> rd_valid)
    else $error("pop from an empty queue");

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("queue count did not follow a push");

endmodule
`default_nettype wire

// File: rtl/core/gwj_div.sv
`default_nettype none
module gwj_div import gwj_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     adv,
  input  wire logic     in_valid,
  input  wire gwj_job_t in_job,
  output logic          out_valid,
  output gwj_dstage_t   out_stage
);

  gwj_dstage_t st_src [NUM_W];
  logic        vld_src [NUM_W];
  gwj_dstage_t st_r   [NUM_W];
  gwj_dstage_t st_nxt [NUM_W];
  logic        vld_r  [NUM_W];

  assign st_src[0].num  = in_job.num;
  assign st_src[0].rem  = '0;
  assign st_src[0].div  = in_job.div;
  assign st_src[0].side = in_job.side;
  assign vld_src[0]     = in_valid;

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    logic           ge;

    if (k > 0) begin : g_link
      assign st_src[k]  = st_r[k-1];
      assign vld_src[k] = vld_r[k-1];
    end

    always_comb begin
      trial          = {st_src[k].rem, st_src[k].num[NUM_W-1]};
      ge             = trial >= {1'b0, st_src[k].div};
      diff           = trial - {1'b0, st_src[k].div};
      st_nxt[k].num  = {st_src[k].num[NUM_W-2:0], ge};
      st_nxt[k].rem  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      st_nxt[k].div  = st_src[k].div;
      st_nxt[k].side = st_src[k].side;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_src[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign out_valid = vld_r[NUM_W-1];
  assign out_stage = st_r[NUM_W-1];

endmodule
`default_nettype wire

// File: rtl/core/gwj_back.sv
`default_nettype none
module gwj_back import gwj_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   head_valid,
  input  wire gwj_job_t               head_job,
  output logic                        pop,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tuser
);

  logic                   adv;
  logic                   dvld;
  gwj_dstage_t            dst;
  logic [NUM_W-1:0]       qm;
  logic [TGT_W-1:0]       step;
  logic [TGT_W+IDX_W-1:0] prod_full;
  gwj_fin_t               fin_r;
  gwj_fin_t               fin_nxt;
  logic                   fin_vld_r;
  logic [X_W-1:0]         x_nxt;
  logic                   out_valid_r;
  logic [X_W-1:0]         out_x_r;
  logic [TGT_W-1:0]       out_adv_r;
  logic                   out_shrunk_r;

  assign adv = !out_valid_r || out_tready;
  assign pop = adv && head_valid;

  gwj_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (head_valid),
    .in_job    (head_job),
    .out_valid (dvld),
    .out_stage (dst)
  );

  always_comb begin
    qm        = dst.num - NUM_W'(dst.side.slot_one);
    step      = dst.side.few_gaps ? TGT_W'(dst.side.slot_one) : dst.num[TGT_W-1:0];
    prod_full = {{IDX_W{1'b0}}, step} * {{TGT_W{1'b0}}, dst.side.idx};

    fin_nxt.mode   = dst.side.mode;
    fin_nxt.shrunk = dst.side.shrunk;
    fin_nxt.target = dst.side.target;
    fin_nxt.front  = dst.side.few_gaps ? qm[TGT_W:1] : TGT_W'(dst.rem[DIV_W-1:1]);
    fin_nxt.prod   = prod_full[X_W-1:0];
    case (dst.side.mode)
      MODE_SHRINK: fin_nxt.x = dst.side.x - dst.num[X_W-1:0];
      default:     fin_nxt.x = dst.side.x;
    endcase
  end

  always_comb begin
    case (fin_r.mode)
      MODE_WIDEN: x_nxt = fin_r.x + X_W'(fin_r.front) + fin_r.prod;
      default:    x_nxt = fin_r.x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      fin_vld_r   <= dvld;
      out_valid_r <= fin_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_r        <= fin_nxt;
      out_x_r      <= x_nxt;
      out_adv_r    <= fin_r.target;
      out_shrunk_r <= fin_r.shrunk;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_adv_r, out_x_r};
  assign out_tuser  = out_shrunk_r;

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !pop ##1 $stable(out_x_r))
    else $error("result changed or queue popped while stalled");

  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> $past(head_valid) && $past(adv))
    else $error("pop without a waiting item and a free pipeline");

  a_fin_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_vld_r && adv) |=> out_valid_r)
    else $error("finished item lost before the output register");

endmodule
`default_nettype wire

// File: rtl/core/glyph_width_justify.sv
// Glyph width justification. Each input item is one glyph of a word: the
// word's target width, current advance, glyph count, the glyph's index and
// its x position, packed in in_tdata. Each item yields exactly one result
// item on the out_ channel, in order: the adjusted x and the new advance in
// out_tdata, and in out_tuser a flag that is set when the word was compressed.
// A compressed word moves each glyph left by a rounded share of the excess; a
// widened word spreads the spare pixels over its gaps with a centred offset.
// Glyphs outside the word, and words whose widths already match, pass as they
// are. The per-glyph division runs in a pipelined restoring divider, one
// quotient bit per stage, 24 stages, followed by two finishing stages.
// Throughput is one item per cycle while the receiver does not stall.
// Accepted items pass through a four-entry queue, so in_tready stays high
// while the pipeline is stalled until that queue is full. When out_tready
// is low while a result is waiting, the whole pipeline holds and the result
// waits in the output register. Reset clears every valid flag and empties
// the queue; no item is in flight afterwards.
`default_nettype none
module glyph_width_justify import gwj_pkg::*; #(
  parameter int MAX_GLYPHS = MAX_GLYPHS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // target_width[14:0], current_advance[29:15], string_length[38:30],
  // glyph_index[46:39], glyph_x[62:47], zero[63].
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // adjusted_x[15:0], new_advance[30:16], zero[31].
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // shrunk[0].
  output logic                        out_tuser
);

  logic     push;
  logic     full;
  logic     pop;
  logic     head_valid;
  gwj_job_t wr_job;
  gwj_job_t head_job;

  gwj_front #(
    .MAX_GLYPHS (MAX_GLYPHS)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .fifo_full (full),
    .push      (push),
    .job       (wr_job)
  );

  gwj_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_job   (wr_job),
    .full     (full),
    .pop      (pop),
    .rd_valid (head_valid),
    .rd_job   (head_job)
  );

  gwj_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// File: sim/tb.sv
`default_nettype none
module tb import gwj_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int ITEMS_PER_PHASE = 300;

  typedef struct packed {
    logic [X_W-1:0]   x;
    logic [TGT_W-1:0] adv;
    logic             shrunk;
  } glyph_result_t;

  typedef struct {
    logic [TGT_W-1:0] tgt;
    logic [TGT_W-1:0] adv;
    logic [LEN_W-1:0] len;
    logic [IDX_W-1:0] idx;
    logic [X_W-1:0]   x;
    bit               known;
    logic [X_W-1:0]   want_x;
    logic             want_shrunk;
  } glyph_case_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  glyph_result_t expected_glyphs[$];
  glyph_case_t   directed_cases[$];
  glyph_result_t head_glyph;

  int idle_in = 0;
  int idle_out = 0;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_compressed = 0;
  int n_widened = 0;
  int quiet_cycles = 0;

  glyph_width_justify u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic glyph_result_t justify_glyph(input logic [TGT_W-1:0] tgt,
                                                  input logic [TGT_W-1:0] adv,
                                                  input logic [LEN_W-1:0] len_in,
                                                  input logic [IDX_W-1:0] idx,
                                                  input logic [X_W-1:0] x);
    logic [63:0]   len;
    logic [63:0]   excess;
    logic [63:0]   move;
    logic [63:0]   gaps;
    logic [63:0]   step;
    logic [63:0]   front;
    logic [63:0]   sum;
    glyph_result_t r;
    len = (len_in > MAX_GLYPHS_DEF) ? 64'(MAX_GLYPHS_DEF) : 64'(len_in);
    r.x = x;
    r.adv = tgt;
    r.shrunk = 1'b0;
    if (tgt < adv) begin
      r.shrunk = 1'b1;
      if (len != 0 && 64'(idx) < len) begin
        excess = 64'(adv) - 64'(tgt);
        move = ((len >> 1) + excess * (64'(idx) + 64'd1)) / len;
        r.x = x - move[X_W-1:0];
      end
    end else if (tgt > adv) begin
      if (len != 0 && 64'(idx) < len) begin
        excess = 64'(tgt) - 64'(adv);
        gaps = len - 64'd1;
        step = (gaps <= 64'd1) ? gaps : excess / gaps;
        front = (excess - step * gaps) >> 1;
        sum = 64'(x) + front + step * 64'(idx);
        r.x = sum[X_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic send_glyph(input logic [TGT_W-1:0] tgt, input logic [TGT_W-1:0] adv,
                            input logic [LEN_W-1:0] len, input logic [IDX_W-1:0] idx,
                            input logic [X_W-1:0] x, input glyph_result_t want);
    if ($urandom_range(99) < idle_in) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_in) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, x, idx, len, adv, tgt};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_glyphs.push_back(want);
    n_sent++;
    if (tgt < adv) n_compressed++;
    else if (tgt > adv) n_widened++;
  endtask

  task automatic send_predicted(input logic [TGT_W-1:0] tgt, input logic [TGT_W-1:0] adv,
                                input logic [LEN_W-1:0] len, input logic [IDX_W-1:0] idx,
                                input logic [X_W-1:0] x);
    send_glyph(tgt, adv, len, idx, x, justify_glyph(tgt, adv, len, idx, x));
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_glyphs.size() != 0) @(posedge clk);
  endtask

  task automatic add_case(input logic [TGT_W-1:0] tgt, input logic [TGT_W-1:0] adv,
                          input logic [LEN_W-1:0] len, input logic [IDX_W-1:0] idx,
                          input logic [X_W-1:0] x, input bit known,
                          input logic [X_W-1:0] want_x, input logic want_shrunk);
    glyph_case_t c;
    c.tgt = tgt;
    c.adv = adv;
    c.len = len;
    c.idx = idx;
    c.x = x;
    c.known = known;
    c.want_x = want_x;
    c.want_shrunk = want_shrunk;
    directed_cases.push_back(c);
  endtask

  function automatic logic [TGT_W-1:0] clip_width(input int w);
    if (w < 0) return '0;
    if (w > 32767) return 15'h7FFF;
    return w[TGT_W-1:0];
  endfunction

  task automatic send_random_words(input int n_items);
    int               sent;
    int               kind;
    int               pitch;
    logic [TGT_W-1:0] adv;
    logic [TGT_W-1:0] tgt;
    logic [LEN_W-1:0] len;
    logic [X_W-1:0]   base;
    int               count;
    sent = 0;
    while (sent < n_items) begin
      adv = TGT_W'($urandom_range(32767));
      kind = $urandom_range(9);
      case (kind)
        0: tgt = adv;
        1: tgt = $urandom_range(1) ? 15'h7FFF : 15'h0000;
        2, 3, 4: tgt = clip_width(int'(adv) + int'($urandom_range(1, 400)));
        5, 6, 7: tgt = clip_width(int'(adv) - int'($urandom_range(1, 400)));
        default: tgt = TGT_W'($urandom_range(32767));
      endcase
      kind = $urandom_range(19);
      if (kind < 14) len = LEN_W'($urandom_range(1, 16));
      else if (kind < 17) len = LEN_W'($urandom_range(17, MAX_GLYPHS_DEF));
      else if (kind == 17) len = '0;
      else len = LEN_W'($urandom_range(MAX_GLYPHS_DEF + 1, 511));
      base = X_W'($urandom_range(65535));
      pitch = $urandom_range(1, 40);
      if ($urandom_range(9) == 0) begin
        send_predicted(tgt, adv, LEN_W'($urandom_range(511)), IDX_W'($urandom_range(255)),
                       X_W'($urandom_range(65535)));
        sent++;
      end else if (len >= 1 && len <= 16) begin
        for (int i = 0; i < len; i++) begin
          send_predicted(tgt, adv, len, i[IDX_W-1:0], base + X_W'(i * pitch));
          sent++;
        end
      end else begin
        count = $urandom_range(1, 6);
        for (int i = 0; i < count; i++) begin
          send_predicted(tgt, adv, len, IDX_W'($urandom_range(255)),
                         X_W'($urandom_range(65535)));
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= idle_out);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_glyphs.size() == 0) begin
        $display("%0t: result with nothing expected: x=%h advance=%h shrunk=%b",
                 $time, out_tdata[15:0], out_tdata[30:16], out_tuser);
        errors++;
      end else begin
        head_glyph = expected_glyphs.pop_front();
        n_checked++;
        if (out_tdata[15:0] !== head_glyph.x) begin
          $display("%0t: adjusted_x expected %h actual %h",
                   $time, head_glyph.x, out_tdata[15:0]);
          errors++;
        end
        if (out_tdata[30:16] !== head_glyph.adv) begin
          $display("%0t: new_advance expected %h actual %h",
                   $time, head_glyph.adv, out_tdata[30:16]);
          errors++;
        end
        if (out_tuser !== head_glyph.shrunk) begin
          $display("%0t: shrunk expected %b actual %b",
                   $time, head_glyph.shrunk, out_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    glyph_result_t want;
    // Matching widths, empty words and glyphs beyond the word leave x alone.
    add_case(15'd100, 15'd100, 9'd5, 8'd2, 16'h04D2, 1, 16'h04D2, 1'b0);
    add_case(15'd0, 15'd0, 9'd1, 8'd0, 16'h0000, 1, 16'h0000, 1'b0);
    add_case(15'h7FFF, 15'h7FFF, 9'h1FF, 8'hFF, 16'hFFFF, 1, 16'hFFFF, 1'b0);
    add_case(15'd10, 15'd50, 9'd0, 8'd0, 16'h0309, 1, 16'h0309, 1'b1);
    add_case(15'd50, 15'd10, 9'd0, 8'd7, 16'h8000, 1, 16'h8000, 1'b0);
    add_case(15'd10, 15'd50, 9'd4, 8'd4, 16'hFFFF, 1, 16'hFFFF, 1'b1);
    add_case(15'd50, 15'd10, 9'd3, 8'd200, 16'h1F40, 1, 16'h1F40, 1'b0);
    add_case(15'd0, 15'd10, 9'd1, 8'd255, 16'h7FFF, 1, 16'h7FFF, 1'b1);
    add_case(15'd0, 15'h7FFF, 9'd1, 8'd0, 16'h0000, 1, 16'h8001, 1'b1);
    add_case(15'h7FFF, 15'd0, 9'd1, 8'd0, 16'h0000, 1, 16'h3FFF, 1'b0);
    add_case(15'd1, 15'd2, 9'd1, 8'd0, 16'hFFFF, 1, 16'hFFFE, 1'b1);
    add_case(15'd20, 15'd10, 9'd2, 8'd1, 16'h0064, 1, 16'h0069, 1'b0);
    add_case(15'd20, 15'd10, 9'd2, 8'd0, 16'h0064, 0, '0, 1'b0);
    add_case(15'd1, 15'd0, 9'd1, 8'd0, 16'h0000, 0, '0, 1'b0);
    add_case(15'd0, 15'h7FFF, 9'd256, 8'd255, 16'h8000, 0, '0, 1'b0);
    add_case(15'h7FFF, 15'd0, 9'd256, 8'd255, 16'h7FFF, 0, '0, 1'b0);
    add_case(15'd1000, 15'h7FFF, 9'h1FF, 8'd255, 16'h5555, 0, '0, 1'b0);
    add_case(15'h7FFF, 15'd0, 9'd257, 8'd128, 16'hAAAA, 0, '0, 1'b0);
    add_case(15'h7FFF, 15'd0, 9'd3, 8'd2, 16'h7FFF, 0, '0, 1'b0);
    add_case(15'd300, 15'd100, 9'd7, 8'd6, 16'h8000, 0, '0, 1'b0);
    add_case(15'd100, 15'd300, 9'd7, 8'd6, 16'h8000, 0, '0, 1'b0);
    add_case(15'h5555, 15'h2AAA, 9'h0AA, 8'h55, 16'h0001, 0, '0, 1'b0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    idle_in = 18;
    idle_out = 83;
    foreach (directed_cases[k]) begin
      if (directed_cases[k].known) begin
        want.x = directed_cases[k].want_x;
        want.adv = directed_cases[k].tgt;
        want.shrunk = directed_cases[k].want_shrunk;
      end else begin
        want = justify_glyph(directed_cases[k].tgt, directed_cases[k].adv,
                             directed_cases[k].len, directed_cases[k].idx,
                             directed_cases[k].x);
      end
      send_glyph(directed_cases[k].tgt, directed_cases[k].adv, directed_cases[k].len,
                 directed_cases[k].idx, directed_cases[k].x, want);
    end
    send_random_words(ITEMS_PER_PHASE);
    wait_for_results();

    idle_in = 83;
    idle_out = 18;
    send_random_words(ITEMS_PER_PHASE / 2);
    wait_for_results();
    send_random_words(ITEMS_PER_PHASE / 2);

    idle_in = 0;
    idle_out = 0;
    send_random_words(ITEMS_PER_PHASE);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_glyphs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d glyphs (%0d shrunk, %0d widened); %0d results checked.",
             n_sent, n_compressed, n_widened, n_checked);
    $display("Throttling ran slow-sender, slow-receiver and free-running phases.");
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
rtl/core/gwj_pkg.sv
rtl/core/gwj_front.sv
rtl/core/gwj_fifo.sv
rtl/core/gwj_div.sv
rtl/core/gwj_back.sv
rtl/core/glyph_width_justify.sv
sim/tb.sv
